### hdl/kcss_pkg.sv
// Shared types and constants for the key counter / seven-segment scan core.
// No dependencies; used by every module in hdl/.
package kcss_pkg;

    localparam int COUNT_W   = 8;
    localparam int SEG_W     = 8;
    localparam int DIGIT_W   = 4;
    localparam int SCAN_W    = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // scan positions, thousands digit first
    localparam logic [SCAN_W-1:0] POS_THOUSANDS = 2'd0;
    localparam logic [SCAN_W-1:0] POS_HUNDREDS  = 2'd1;
    localparam logic [SCAN_W-1:0] POS_TENS      = 2'd2;
    localparam logic [SCAN_W-1:0] POS_UNITS     = 2'd3;

    // active-low digit selects
    localparam logic [DIGIT_W-1:0] SEL_THOUSANDS = 4'h7;
    localparam logic [DIGIT_W-1:0] SEL_HUNDREDS  = 4'hb;
    localparam logic [DIGIT_W-1:0] SEL_TENS      = 4'hd;
    localparam logic [DIGIT_W-1:0] SEL_UNITS     = 4'he;

    // key levels of one request, 0 means pressed
    typedef struct packed {
        logic clear;
        logic minus_ten;
        logic plus_ten;
        logic minus_one;
        logic plus_one;
    } keys_t;

    // common-anode pattern for a decimal digit, bit0 = segment a
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'hc0;
            4'd1:    code = 8'hf9;
            4'd2:    code = 8'ha4;
            4'd3:    code = 8'hb0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hf8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hc0;
        endcase
        return code;
    endfunction

endpackage

### hdl/kcss_counter.sv
// Count, released flag and scan position registers with the key action logic.
// Depends on kcss_pkg.
module kcss_counter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  kcss_pkg::keys_t               keys,
    output logic [kcss_pkg::COUNT_W-1:0]  count_next,
    output logic [kcss_pkg::SCAN_W-1:0]   scan_pos
);

    logic [kcss_pkg::COUNT_W-1:0] count_reg;
    logic                         released_reg;
    logic                         released_next;
    logic [kcss_pkg::SCAN_W-1:0]  scan_reg;
    logic                         any_down;

    assign any_down = ~&keys;
    assign scan_pos = scan_reg;

    always_comb begin
        count_next    = count_reg;
        released_next = released_reg;
        if (any_down) begin
            if (released_reg) begin
                // priority: +1, -1, +10, -10, clear
                if (!keys.plus_one) begin
                    count_next = count_reg + 8'd1;
                end else if (!keys.minus_one) begin
                    count_next = count_reg - 8'd1;
                end else if (!keys.plus_ten) begin
                    count_next = count_reg + 8'd10;
                end else if (!keys.minus_ten) begin
                    count_next = count_reg - 8'd10;
                end else begin
                    count_next = '0;
                end
                released_next = 1'b0;
            end
        end else begin
            released_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            released_reg <= 1'b1;
            scan_reg     <= kcss_pkg::POS_THOUSANDS;
        end else if (step) begin
            count_reg    <= count_next;
            released_reg <= released_next;
            scan_reg     <= scan_reg + 2'd1;
        end
    end

`ifndef SYNTH
    a_scan_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> scan_reg == 2'($past(scan_reg) + 2'd1))
        else $error("scan position did not advance by one");

    a_hold_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(count_reg) && $stable(released_reg))
        else $error("state changed without a request");

    a_held_key: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !released_reg |=> $stable(count_reg))
        else $error("count changed while a key was held");
`endif

endmodule

### hdl/kcss_digit_decode.sv
// Picks the scanned decimal digit of the count and maps it to segments and select.
// Depends on kcss_pkg.
module kcss_digit_decode (
    input  logic [kcss_pkg::COUNT_W-1:0]  count,
    input  logic [kcss_pkg::SCAN_W-1:0]   scan_pos,
    output logic [kcss_pkg::SEG_W-1:0]    segment_pattern,
    output logic [kcss_pkg::DIGIT_W-1:0]  digit_enable
);

    logic [1:0]  hundreds;
    logic [6:0]  rem;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  units_full;
    logic [3:0]  digit;

    always_comb begin
        if (count >= 8'd200) begin
            hundreds = 2'd2;
            rem      = 7'(count - 8'd200);
        end else if (count >= 8'd100) begin
            hundreds = 2'd1;
            rem      = 7'(count - 8'd100);
        end else begin
            hundreds = 2'd0;
            rem      = count[6:0];
        end
    end

    // rem / 10 as rem * 205 >> 11, exact for rem < 100
    assign tens_prod  = 15'(rem) * 15'd205;
    assign tens       = tens_prod[14:11];
    assign units_full = rem - 7'(tens) * 7'd10;

    always_comb begin
        unique case (scan_pos)
            kcss_pkg::POS_THOUSANDS: begin
                digit        = 4'd0;
                digit_enable = kcss_pkg::SEL_THOUSANDS;
            end
            kcss_pkg::POS_HUNDREDS: begin
                digit        = {2'b00, hundreds};
                digit_enable = kcss_pkg::SEL_HUNDREDS;
            end
            kcss_pkg::POS_TENS: begin
                digit        = tens;
                digit_enable = kcss_pkg::SEL_TENS;
            end
            default: begin
                digit        = units_full[3:0];
                digit_enable = kcss_pkg::SEL_UNITS;
            end
        endcase
    end

    assign segment_pattern = kcss_pkg::seg_code(digit);

endmodule

### hdl/key_counter_seven_segment_scan_core.sv
// Top level of the key counter / seven-segment scan core.
// Depends on kcss_pkg, kcss_counter and kcss_digit_decode.
//
// Usage:
//   Slave stream: one request per scan tick, s_tdata[4:0] carries the five
//   active-low key levels. Keys act in priority +1, -1, +10, -10, clear, and
//   only on the first tick of a press; the 8-bit count wraps modulo 256.
//   Master stream: one result per request with the segment pattern of the
//   scanned digit (thousands first), its active-low digit select and the
//   count after the key action.
//   Path: an accepted request enters the input register, then the result
//   register, which drives m_tvalid. Throughput: one request per cycle
//   while m_tready does not stall the output, set by the combinational
//   count update between the two registers.
//   Reset: count 0, released flag set, scan at the thousands digit; both
//   pipeline registers empty.
//   Stall: a held result stays on m_tdata; the input register still takes
//   one more request, after which s_tready drops until m_tready returns.
module key_counter_seven_segment_scan_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] key_plus_one, [1] key_minus_one, [2] key_plus_ten,
    // [3] key_minus_ten, [4] key_clear, [7:5] zero
    input  logic [kcss_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] segment_pattern, [11:8] digit_enable, [19:12] shown_count,
    // [23:20] zero
    output logic [kcss_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic                          in_valid_reg;
    kcss_pkg::keys_t               keys_reg;
    logic                          out_valid_reg;
    logic [kcss_pkg::SEG_W-1:0]    seg_reg;
    logic [kcss_pkg::DIGIT_W-1:0]  sel_reg;
    logic [kcss_pkg::COUNT_W-1:0]  shown_reg;

    logic                          advance;
    logic                          fire;
    logic                          s_fire;
    logic [kcss_pkg::COUNT_W-1:0]  count_next;
    logic [kcss_pkg::SCAN_W-1:0]   scan_pos;
    logic [kcss_pkg::SEG_W-1:0]    seg_next;
    logic [kcss_pkg::DIGIT_W-1:0]  sel_next;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    kcss_counter u_counter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (fire),
        .keys       (keys_reg),
        .count_next (count_next),
        .scan_pos   (scan_pos)
    );

    kcss_digit_decode u_decode (
        .count           (count_next),
        .scan_pos        (scan_pos),
        .segment_pattern (seg_next),
        .digit_enable    (sel_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            keys_reg.plus_one  <= s_tdata[0];
            keys_reg.minus_one <= s_tdata[1];
            keys_reg.plus_ten  <= s_tdata[2];
            keys_reg.minus_ten <= s_tdata[3];
            keys_reg.clear     <= s_tdata[4];
        end
        if (fire) begin
            seg_reg   <= seg_next;
            sel_reg   <= sel_next;
            shown_reg <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, shown_reg, sel_reg, seg_reg};

`ifndef SYNTH
    a_one_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(~m_tdata[11:8]))
        else $error("result selects other than exactly one digit");
`endif

endmodule

### verif/tb.sv
// Testbench for key_counter_seven_segment_scan_core: key press requests in, scan results out.
// Depends on kcss_pkg and the RTL in hdl/. A scoreboard class predicts count, flag and scan
// digit per request; plain tasks drive the slave stream, a random process stalls the master.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int TAIL_CYCLES    = 10;
    localparam int WATCHDOG_CYCLES = 400000;

    typedef enum int {
        KEY_PLUS_ONE  = 0,
        KEY_MINUS_ONE = 1,
        KEY_PLUS_TEN  = 2,
        KEY_MINUS_TEN = 3,
        KEY_CLEAR     = 4
    } key_id_t;

    localparam kcss_pkg::keys_t KEYS_RELEASED = '1;

    typedef struct {
        logic [kcss_pkg::SEG_W-1:0]   segments;
        logic [kcss_pkg::DIGIT_W-1:0] digit_sel;
        logic [kcss_pkg::COUNT_W-1:0] count;
    } scan_result_t;

    // Tracks the counter and scan position, queues one expected scan result per request
    class count_display_scoreboard;
        logic [kcss_pkg::COUNT_W-1:0] count;
        bit                           released;
        logic [kcss_pkg::SCAN_W-1:0]  scan_pos;
        scan_result_t                 expected_q[$];
        int                           errors;
        int                           requests;
        int                           results;
        int                           key_actions;
        bit                           count_seen[256];

        logic [kcss_pkg::SEG_W-1:0] seg_table[10] = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99,
                                                      8'h92, 8'h82, 8'hf8, 8'h80, 8'h90};

        function new();
            count    = '0;
            released = 1'b1;
            scan_pos = kcss_pkg::POS_THOUSANDS;
        endfunction

        function void note_request(kcss_pkg::keys_t k);
            scan_result_t exp_res;
            int           digit;
            requests++;
            if (k != KEYS_RELEASED) begin
                // first-priority key wins, and only on the first tick of a press
                if (released) begin
                    if (!k.plus_one)
                        count = count + 8'd1;
                    else if (!k.minus_one)
                        count = count - 8'd1;
                    else if (!k.plus_ten)
                        count = count + 8'd10;
                    else if (!k.minus_ten)
                        count = count - 8'd10;
                    else
                        count = '0;
                    released = 1'b0;
                    key_actions++;
                end
            end else begin
                released = 1'b1;
            end
            case (scan_pos)
                kcss_pkg::POS_THOUSANDS: begin
                    digit = (int'(count) / 1000) % 10;
                    exp_res.digit_sel = kcss_pkg::SEL_THOUSANDS;
                end
                kcss_pkg::POS_HUNDREDS: begin
                    digit = (int'(count) / 100) % 10;
                    exp_res.digit_sel = kcss_pkg::SEL_HUNDREDS;
                end
                kcss_pkg::POS_TENS: begin
                    digit = (int'(count) / 10) % 10;
                    exp_res.digit_sel = kcss_pkg::SEL_TENS;
                end
                default: begin
                    digit = int'(count) % 10;
                    exp_res.digit_sel = kcss_pkg::SEL_UNITS;
                end
            endcase
            exp_res.segments = seg_table[digit];
            exp_res.count    = count;
            count_seen[count] = 1'b1;
            expected_q.push_back(exp_res);
            scan_pos = scan_pos + 2'd1;
        endfunction

        function void check_result(logic [kcss_pkg::M_TDATA_W-1:0] data);
            scan_result_t exp_res;
            results++;
            if (expected_q.size() == 0) begin
                $error("unexpected scan result %h", data);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (data[7:0] !== exp_res.segments) begin
                $error("segment_pattern: expected %h, got %h", exp_res.segments, data[7:0]);
                errors++;
            end
            if (data[11:8] !== exp_res.digit_sel) begin
                $error("digit_enable: expected %h, got %h", exp_res.digit_sel, data[11:8]);
                errors++;
            end
            if (data[19:12] !== exp_res.count) begin
                $error("shown_count: expected %0d, got %0d", exp_res.count, data[19:12]);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function int distinct_counts();
            int n;
            n = 0;
            foreach (count_seen[i])
                if (count_seen[i])
                    n++;
            return n;
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [kcss_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [kcss_pkg::M_TDATA_W-1:0] m_tdata;

    count_display_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off_pending;

    key_counter_seven_segment_scan_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    initial begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("timeout waiting for scan results");
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    function automatic kcss_pkg::keys_t press(key_id_t id);
        kcss_pkg::keys_t k;
        k = KEYS_RELEASED;
        k[id] = 1'b0;
        return k;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_keys(kcss_pkg::keys_t k);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= kcss_pkg::S_TDATA_W'(k);
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_request(k);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge aclk);
    endtask

    task automatic run_random(int n_items);
        int              sent;
        int              hold;
        int              rel;
        kcss_pkg::keys_t k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 75) begin
                // a press held for a few ticks, then released
                k = press(key_id_t'($urandom_range(KEY_PLUS_ONE, KEY_CLEAR)));
                if ($urandom_range(0, 4) == 0)
                    k = k & kcss_pkg::keys_t'($urandom);
                hold = $urandom_range(1, 3);
                rel  = $urandom_range(1, 2);
                repeat (hold) send_keys(k);
                repeat (rel) send_keys(KEYS_RELEASED);
                sent += hold + rel;
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_keys(kcss_pkg::keys_t'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_pending = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: each key, held keys, priority, wrap-around both ways
        send_keys(KEYS_RELEASED);
        send_keys(press(KEY_PLUS_ONE));
        send_keys(press(KEY_PLUS_ONE));
        send_keys(KEYS_RELEASED);
        send_keys(press(KEY_MINUS_ONE));
        send_keys(KEYS_RELEASED);
        send_keys(press(KEY_MINUS_ONE));        // 0 -> 255
        send_keys(KEYS_RELEASED);
        send_keys(press(KEY_PLUS_ONE));         // 255 -> 0
        send_keys(KEYS_RELEASED);
        send_keys(press(KEY_MINUS_TEN));        // 0 -> 246
        send_keys(KEYS_RELEASED);
        send_keys(press(KEY_PLUS_TEN));         // 246 -> 0
        send_keys(KEYS_RELEASED);
        send_keys(press(KEY_PLUS_TEN));
        send_keys(press(KEY_MINUS_TEN));       // another key during a held press does nothing
        send_keys(KEYS_RELEASED);
        send_keys(kcss_pkg::keys_t'('0));       // all keys down, +1 wins
        send_keys(KEYS_RELEASED);
        send_keys(press(KEY_CLEAR) & press(KEY_MINUS_TEN));
        send_keys(KEYS_RELEASED);
        send_keys(press(KEY_CLEAR));
        send_keys(press(KEY_CLEAR));
        send_keys(KEYS_RELEASED);
        wait_drained();

        // no idling, with one long result-side hold-off while requests keep coming
        hold_off_pending = 1'b1;
        run_random(RANDOM_ITEMS / 4);
        wait_drained();

        send_idle_pct = 46;
        recv_stall_pct = 0;
        run_random(RANDOM_ITEMS / 4);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 46;
        run_random(RANDOM_ITEMS / 4);
        wait_drained();

        send_idle_pct = 18;
        recv_stall_pct = 18;
        run_random(RANDOM_ITEMS / 4);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("%0d key requests, %0d scan results checked, %0d key actions",
                 sb.requests, sb.results, sb.key_actions);
        $display("%0d distinct count values shown across four idling phases",
                 sb.distinct_counts());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
